// ----- sv/sfrcc_pkg.sv -----
// Shared types, constants and the CRC step of the stuffed frame receiver.
package sfrcc_pkg;

  localparam int MAX_FRAME_BYTES = 64;
  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME_BYTES);

  localparam logic [7:0] FLAG_BYTE = 8'h7e;
  localparam logic [7:0] ESC_BYTE = 8'h7d;
  localparam logic [7:0] ESC_XOR = 8'h20;
  localparam logic [7:0] TYPE_ACK = 8'h43;
  localparam logic [7:0] TYPE_DATA = 8'h45;
  localparam logic [7:0] CMD_SENSOR = 8'h01;
  localparam logic [7:0] SUB_SENSOR = 8'h05;
  localparam logic [7:0] DLEN_SENSOR = 8'h0a;
  localparam logic [7:0] CMD_FAN = 8'h03;
  localparam logic [7:0] SUB_FAN_ON = 8'h11;
  localparam logic [7:0] SUB_FAN_OFF = 8'h12;
  localparam logic [7:0] OWN_ID_RESET = 8'h5e;

  localparam logic [2:0] KIND_SHORT = 3'd0;
  localparam logic [2:0] KIND_CRC_ERR = 3'd1;
  localparam logic [2:0] KIND_ACK = 3'd2;
  localparam logic [2:0] KIND_SENSOR = 3'd3;
  localparam logic [2:0] KIND_FAN_ON = 3'd4;
  localparam logic [2:0] KIND_FAN_OFF = 3'd5;
  localparam logic [2:0] KIND_IGNORED = 3'd6;

  // Fields of a frame at its closing flag.
  typedef struct packed {
    logic close;
    logic [CNT_W-1:0] count;
    logic crc_ok;
    logic [7:0] ftype;
    logic [7:0] mod_id;
    logic [7:0] cmd;
    logic [7:0] sub;
    logic [7:0] dlen;
    logic [31:0] sensor;
  } frame_t;

  typedef struct packed {
    logic [2:0] frame_kind;
    logic [15:0] temp_raw;
    logic [15:0] humi_raw;
    logic [6:0] frame_length;
  } result_t;

  // One byte of CRC-16/CCITT, bytewise shift-and-xor form.
  function automatic logic [15:0] crc_step(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = {crc_in[7:0], crc_in[15:8]};
    c[7:0] = c[7:0] ^ b;
    c = c ^ {12'd0, c[7:4]};
    c = c ^ {c[3:0], 12'd0};
    c = c ^ {3'd0, c[7:0], 5'd0};
    return c;
  endfunction

endpackage

// ----- sv/sfrcc_deframer.sv -----
// Flag detection, unstuffing, running CRC and header capture; one byte per en cycle.
module sfrcc_deframer (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic [7:0] rx_byte,
  output sfrcc_pkg::frame_t frame
);

  logic [7:0] previous_byte;
  logic frame_open;
  logic escape_pending;
  logic [sfrcc_pkg::CNT_W-1:0] byte_count;
  logic [15:0] crc_lagged;
  logic [15:0] last_two_bytes;
  logic [7:0] ftype, mod_id, cmd, sub, dlen;
  logic [31:0] sensor_words;

  logic is_flag, is_esc, has_room;
  logic [7:0] value;

  assign is_flag = (rx_byte == sfrcc_pkg::FLAG_BYTE);
  assign is_esc = (rx_byte == sfrcc_pkg::ESC_BYTE);
  assign has_room = (byte_count < sfrcc_pkg::MAX_CNT);
  assign value = escape_pending ? (rx_byte ^ sfrcc_pkg::ESC_XOR) : rx_byte;

  always_comb begin
    frame.close = en && is_flag && (previous_byte != sfrcc_pkg::FLAG_BYTE) &&
                  frame_open && has_room;
    frame.count = byte_count;
    frame.crc_ok = (crc_lagged == last_two_bytes);
    frame.ftype = ftype;
    frame.mod_id = mod_id;
    frame.cmd = cmd;
    frame.sub = sub;
    frame.dlen = dlen;
    frame.sensor = sensor_words;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_byte <= sfrcc_pkg::FLAG_BYTE;
      frame_open <= 1'b0;
      escape_pending <= 1'b0;
      byte_count <= '0;
      crc_lagged <= '0;
      last_two_bytes <= '0;
      ftype <= '0;
      mod_id <= '0;
      cmd <= '0;
      sub <= '0;
      dlen <= '0;
      sensor_words <= '0;
    end else if (en) begin
      previous_byte <= rx_byte;
      if (is_flag) begin
        escape_pending <= 1'b0;
        if (previous_byte == sfrcc_pkg::FLAG_BYTE) begin
          frame_open <= 1'b1;
          byte_count <= '0;
          crc_lagged <= '0;
          last_two_bytes <= '0;
          ftype <= '0;
          mod_id <= '0;
          cmd <= '0;
          sub <= '0;
          dlen <= '0;
          sensor_words <= '0;
        end else begin
          frame_open <= 1'b0;
        end
      end else if (is_esc && frame_open) begin
        escape_pending <= 1'b1;
      end else if (frame_open) begin
        escape_pending <= 1'b0;
        if (has_room) begin
          // The CRC trails by two bytes so the received CRC never enters it.
          if (byte_count >= sfrcc_pkg::CNT_W'(2)) begin
            crc_lagged <= sfrcc_pkg::crc_step(crc_lagged, last_two_bytes[7:0]);
          end
          last_two_bytes <= {value, last_two_bytes[15:8]};
          byte_count <= byte_count + 1'b1;
          case (byte_count)
            sfrcc_pkg::CNT_W'(0):  ftype <= value;
            sfrcc_pkg::CNT_W'(9):  mod_id <= value;
            sfrcc_pkg::CNT_W'(10): cmd <= value;
            sfrcc_pkg::CNT_W'(11): sub <= value;
            sfrcc_pkg::CNT_W'(12): dlen <= value;
            sfrcc_pkg::CNT_W'(15): sensor_words[7:0] <= value;
            sfrcc_pkg::CNT_W'(16): sensor_words[15:8] <= value;
            sfrcc_pkg::CNT_W'(17): sensor_words[23:16] <= value;
            sfrcc_pkg::CNT_W'(18): sensor_words[31:24] <= value;
            default: ;
          endcase
        end else begin
          frame_open <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- sv/sfrcc_classify.sv -----
// Classification of a closed frame into its result item.
module sfrcc_classify (
  input  sfrcc_pkg::frame_t frame,
  input  logic [7:0] own_module_id,
  output sfrcc_pkg::result_t result
);

  logic is_sensor_hdr;
  logic [2:0] kind;

  assign is_sensor_hdr = (frame.cmd == sfrcc_pkg::CMD_SENSOR) &&
                         (frame.sub == sfrcc_pkg::SUB_SENSOR) &&
                         (frame.dlen == sfrcc_pkg::DLEN_SENSOR);

  always_comb begin
    if (frame.count < sfrcc_pkg::CNT_W'(3)) begin
      kind = sfrcc_pkg::KIND_SHORT;
    end else if (!frame.crc_ok) begin
      kind = sfrcc_pkg::KIND_CRC_ERR;
    end else if (frame.ftype == sfrcc_pkg::TYPE_ACK) begin
      kind = sfrcc_pkg::KIND_ACK;
    end else if (frame.ftype != sfrcc_pkg::TYPE_DATA) begin
      kind = sfrcc_pkg::KIND_IGNORED;
    end else if (frame.count < sfrcc_pkg::CNT_W'(15)) begin
      kind = sfrcc_pkg::KIND_SHORT;
    end else if (frame.mod_id != own_module_id) begin
      kind = sfrcc_pkg::KIND_IGNORED;
    end else if (is_sensor_hdr) begin
      kind = (frame.count < sfrcc_pkg::CNT_W'(25)) ? sfrcc_pkg::KIND_SHORT
                                                   : sfrcc_pkg::KIND_SENSOR;
    end else if (frame.cmd == sfrcc_pkg::CMD_FAN && frame.sub == sfrcc_pkg::SUB_FAN_ON) begin
      kind = sfrcc_pkg::KIND_FAN_ON;
    end else if (frame.cmd == sfrcc_pkg::CMD_FAN && frame.sub == sfrcc_pkg::SUB_FAN_OFF) begin
      kind = sfrcc_pkg::KIND_FAN_OFF;
    end else begin
      kind = sfrcc_pkg::KIND_IGNORED;
    end
  end

  always_comb begin
    result.frame_kind = kind;
    result.temp_raw = (kind == sfrcc_pkg::KIND_SENSOR) ? frame.sensor[15:0] : 16'd0;
    result.humi_raw = (kind == sfrcc_pkg::KIND_SENSOR) ? frame.sensor[31:16] : 16'd0;
    result.frame_length = 7'(frame.count);
  end

endmodule

// ----- sv/stuffed_frame_receiver_crc_check.sv -----
// Receives byte-stuffed frames, checks CRC-16/CCITT and emits one classified result per
// closed frame. An item is taken every cycle unless the pipeline is held: the byte is
// registered in the input register, then processed from there by the deframer and
// classifier, and the result is captured in the output register. A stalled output holds
// the pipeline only while both the input register and the output register are full.
// There is no clearing pass after reset.
module stuffed_frame_receiver_crc_check (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // rx_byte
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [39:0] m_axis_tdata,  // temp_raw, humi_raw, frame_length, zero fill
  output logic [2:0] m_axis_tuser,   // frame_kind
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [7:0] cfg_data        // own_module_id
);

  logic in_valid;
  logic [7:0] in_byte;
  logic advance;
  logic [7:0] own_module_id;
  sfrcc_pkg::frame_t frame;
  sfrcc_pkg::result_t result;
  sfrcc_pkg::result_t out_reg;

  assign advance = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_module_id <= sfrcc_pkg::OWN_ID_RESET;
    end else if (cfg_valid) begin
      own_module_id <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
    end
  end

  sfrcc_deframer u_deframer (
    .clk     (clk),
    .rst     (rst),
    .en      (in_valid && advance),
    .rx_byte (in_byte),
    .frame   (frame)
  );

  sfrcc_classify u_classify (
    .frame         (frame),
    .own_module_id (own_module_id),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= frame.close;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && frame.close) begin
      out_reg <= result;
    end
  end

  assign m_axis_tuser = out_reg.frame_kind;
  assign m_axis_tdata = {1'b0, out_reg.frame_length, out_reg.humi_raw, out_reg.temp_raw};

endmodule

// ----- sv/sfrcc_checker.sv -----
// Port-level checker for the stuffed frame receiver, bound to the top level.
module sfrcc_checker (
  input logic clk,
  input logic rst,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [2:0] m_axis_tuser
);

  // A stalled result item holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result item changed while stalled");

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result item shown right after reset");

  // Sensor words are only carried by sensor frames.
  a_sensor_only: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != sfrcc_pkg::KIND_SENSOR |-> m_axis_tdata[31:0] == 32'd0)
    else $error("sensor words on a non-sensor result");

  // Any result that is not short is longer than two bytes; overflowed frames never report.
  a_length: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[38:32] < 7'(sfrcc_pkg::MAX_FRAME_BYTES) &&
      (m_axis_tuser == sfrcc_pkg::KIND_SHORT || m_axis_tdata[38:32] >= 7'd3))
    else $error("frame length inconsistent with frame kind");

  // A sensor result needs a full sensor frame.
  a_sensor_len: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == sfrcc_pkg::KIND_SENSOR |-> m_axis_tdata[38:32] >= 7'd25)
    else $error("sensor result from a short frame");

endmodule

bind stuffed_frame_receiver_crc_check sfrcc_checker u_sfrcc_checker (.*);
